@@ design/sorted_list_intersection_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the sorted list intersection block.
// Both macros sample on clk and are disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INTERSECTION_ASSERT_SVH
`define SORTED_LIST_INTERSECTION_ASSERT_SVH

// Same-cycle implication
`define SLI_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SLI_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sli_pkg.sv @@
// ---------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the sorted list intersection block.
// ---------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

    // Document id width
    localparam int ID_W = 31;

    // Active list count register
    localparam int CFG_W = 3;
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 3'd2;

    // Request codes
    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_NEXT   = 2'd2,
        REQ_SKIP   = 2'd3
    } req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_ADV,
        ST_WAIT,
        ST_RESULT
    } state_t;

    // One query answer
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            exhausted;
    } result_t;

endpackage

`default_nettype wire

@@ design/sli_ram.sv @@
// ---------------------------------------------------------------------------
// sli_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sli_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ design/sli_core.sv @@
// ---------------------------------------------------------------------------
// sli_core
// List bookkeeping and leapfrog sequencer. Lengths, cursors and cached
// heads live in flops; list contents live in the external RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module sli_core
    import sli_pkg::*;
#(
    parameter int NUM_LISTS = 4,
    parameter int LIST_DEPTH = 1024,
    localparam int ADDR_W = $clog2(NUM_LISTS) + $clog2(LIST_DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request side
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [1:0]        list_index,
    input  wire logic [ID_W-1:0]   doc_id,
    // configuration
    input  wire logic [CFG_W-1:0]  active_lists,
    input  wire logic              cfg_restart,
    // result side
    input  wire logic              res_free,
    output logic                   res_valid,
    output result_t                res,
    // list memory
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic [ID_W-1:0]        mem_wdata,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  wire logic [ID_W-1:0]   mem_rdata
);

    localparam int LIST_W = $clog2(NUM_LISTS);
    localparam int POS_W  = $clog2(LIST_DEPTH);
    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int CNT_W  = $clog2(NUM_LISTS + 1);

    state_t state_reg, state_next;

    logic [LEN_W-1:0] len_reg   [NUM_LISTS];
    logic [LEN_W-1:0] len_next  [NUM_LISTS];
    logic [LEN_W-1:0] cur_reg   [NUM_LISTS];
    logic [LEN_W-1:0] cur_next  [NUM_LISTS];
    logic [ID_W-1:0]  head_reg  [NUM_LISTS];
    logic [ID_W-1:0]  head_next [NUM_LISTS];
    logic [ID_W-1:0]  first_reg [NUM_LISTS];
    logic [ID_W-1:0]  first_next[NUM_LISTS];
    logic [ID_W-1:0]  last_reg  [NUM_LISTS];
    logic [ID_W-1:0]  last_next [NUM_LISTS];

    logic [ID_W-1:0]   top_reg, top_next;
    logic [LIST_W-1:0] sel_reg, sel_next;
    logic              started_reg, started_next;
    logic              finished_reg, finished_next;

    logic              in_fire;
    req_t              req;
    logic              is_query;
    logic              do_restart;
    logic [CNT_W-1:0]  used_n;
    logic [LIST_W-1:0] back;
    logic [NUM_LISTS-1:0] act, has, hi_hit, lo_hit;
    logic              miss, any_hi, any_lo;
    logic [LIST_W-1:0] hi_idx, lo_idx;
    logic [LIST_W-1:0] p;
    logic              idx_ok;
    logic [LEN_W-1:0]  len_p, cur_p, step_cur;
    logic [ID_W-1:0]   last_p;
    logic              step_out;
    logic              app_ok;
    logic              stepping;

    assign in_fire    = in_valid && in_ready;
    assign req        = req_t'(req_type);
    assign is_query   = (req == REQ_NEXT) || (req == REQ_SKIP);
    assign do_restart = cfg_restart ||
                        (in_fire && ((req == REQ_CLEAR) || (req == REQ_APPEND)));

    // Clamp the active list count to 1..NUM_LISTS
    always_comb
    begin
        if (active_lists == '0)
        begin
            used_n = CNT_W'(1);
        end
        else if (32'(active_lists) > NUM_LISTS)
        begin
            used_n = CNT_W'(NUM_LISTS);
        end
        else
        begin
            used_n = CNT_W'(active_lists);
        end
    end

    assign back = LIST_W'(used_n - CNT_W'(1));

    // Per-list status, compared against the current target
    always_comb
    begin
        for (int i = 0; i < NUM_LISTS; i++)
        begin
            act[i]    = int'(used_n) > i;
            has[i]    = cur_reg[i] < len_reg[i];
            hi_hit[i] = act[i] && (head_reg[i] > top_reg);
            lo_hit[i] = act[i] && (head_reg[i] < top_reg);
        end
    end

    assign miss   = |(act & ~has);
    assign any_hi = |hi_hit;
    assign any_lo = |lo_hit;

    // Lowest-numbered list above / below the target
    always_comb
    begin
        hi_idx = '0;
        lo_idx = '0;
        for (int i = NUM_LISTS - 1; i >= 0; i--)
        begin
            if (hi_hit[i])
            begin
                hi_idx = LIST_W'(i);
            end
            if (lo_hit[i])
            begin
                lo_idx = LIST_W'(i);
            end
        end
    end

    // Single list port: append target when idle, else the list being stepped
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  p = LIST_W'(list_index);
            ST_ADV:   p = back;
            default:  p = lo_idx;
        endcase
    end

    assign idx_ok   = 32'(list_index) < NUM_LISTS;
    assign len_p    = len_reg[p];
    assign cur_p    = cur_reg[p];
    assign last_p   = last_reg[p];
    assign step_cur = cur_p + LEN_W'(1);
    assign step_out = step_cur == len_p;
    assign app_ok   = idx_ok && (32'(len_p) < LIST_DEPTH) &&
                      ((len_p == '0) || (doc_id > last_p));
    assign stepping = ((state_reg == ST_ALIGN) && !miss && !any_hi && any_lo) ||
                      (state_reg == ST_ADV);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_query)
                begin
                    if (finished_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else if ((req == REQ_NEXT) && started_reg)
                    begin
                        state_next = ST_ADV;
                    end
                    else
                    begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN:
            begin
                if (miss)
                begin
                    state_next = ST_RESULT;
                end
                else if (any_hi)
                begin
                    state_next = ST_ALIGN;
                end
                else if (any_lo)
                begin
                    state_next = step_out ? ST_RESULT : ST_WAIT;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ADV:
            begin
                state_next = step_out ? ST_RESULT : ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_ALIGN;
            end
            ST_RESULT:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = state_reg == ST_IDLE;
        mem_we        = (state_reg == ST_IDLE) && in_fire && (req == REQ_APPEND) && app_ok;
        mem_waddr     = {p, len_p[POS_W-1:0]};
        mem_wdata     = doc_id;
        mem_re        = stepping && !step_out;
        mem_raddr     = {p, step_cur[POS_W-1:0]};
        res_valid     = (state_reg == ST_RESULT) && res_free;
        res.id        = finished_reg ? '0 : head_reg[0];
        res.exhausted = finished_reg;
    end

    // List state and iteration bookkeeping
    always_comb
    begin
        len_next      = len_reg;
        cur_next      = cur_reg;
        head_next     = head_reg;
        first_next    = first_reg;
        last_next     = last_reg;
        top_next      = top_reg;
        sel_next      = sel_reg;
        started_next  = started_reg;
        finished_next = finished_reg;

        // Requests taken while idle
        if (in_fire)
        begin
            case (req)
                REQ_CLEAR:
                begin
                    for (int i = 0; i < NUM_LISTS; i++)
                    begin
                        len_next[i] = '0;
                    end
                end
                REQ_APPEND:
                begin
                    if (app_ok)
                    begin
                        len_next[p]  = len_p + LEN_W'(1);
                        last_next[p] = doc_id;
                        if (len_p == '0)
                        begin
                            first_next[p] = doc_id;
                        end
                    end
                end
                default:
                begin
                    started_next = 1'b1;
                    top_next     = (req == REQ_SKIP) ? doc_id : '0;
                end
            endcase
        end

        // Leapfrog: an exhausted active list ends it, a higher head raises the target
        if (state_reg == ST_ALIGN)
        begin
            if (miss)
            begin
                finished_next = 1'b1;
            end
            else if (any_hi)
            begin
                top_next = head_reg[hi_idx];
            end
        end

        // Cursor advance; the RAM read returns the new head, which is loaded in ST_WAIT
        if (stepping)
        begin
            cur_next[p] = step_cur;
            sel_next    = p;
            if (step_out)
            begin
                finished_next = 1'b1;
            end
        end

        if (state_reg == ST_WAIT)
        begin
            head_next[sel_reg] = mem_rdata;
        end

        // Restart: cursors back to the first entries
        if (do_restart)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                cur_next[i]  = '0;
                head_next[i] = first_next[i];
            end
            started_next  = 1'b0;
            finished_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                len_reg[i] <= '0;
                cur_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            len_reg      <= len_next;
            cur_reg      <= cur_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg  <= head_next;
        first_reg <= first_next;
        last_reg  <= last_next;
        top_reg   <= top_next;
        sel_reg   <= sel_next;
    end

endmodule

`default_nettype wire

@@ design/sorted_list_intersection.sv @@
// ---------------------------------------------------------------------------
// sorted_list_intersection
// Holds NUM_LISTS ascending id lists and walks their intersection.
//
// Request channel (in_valid/in_ready): clear, append, next, skip. Clear and
// append complete in the cycle of the transfer and give no result. Next and
// skip each give one result on the out channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready): active list count, always ready;
// write it only while no query is in flight.
// A query walks the lists in the sequencer: each target raise takes another
// alignment pass, and each cursor advance that loads a new head issues one
// RAM read and loads the head in a wait state. An advance that runs off the
// end of its list ends the walk without a RAM read. A query on an exhausted
// iteration goes straight to the result state.
// One query is in flight at a time; in_ready is low while it walks the lists.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls with a result already held, the next query
// finishes and then waits.
// Reset empties all lists and sets the active count to 2; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_list_intersection
    import sli_pkg::*;
#(
    parameter int NUM_LISTS = 4,
    parameter int LIST_DEPTH = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [1:0]        list_index,
    input  wire logic [ID_W-1:0]   doc_id,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ID_W-1:0]        result_id,
    output logic                   exhausted,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int ADDR_W    = $clog2(NUM_LISTS) + $clog2(LIST_DEPTH);
    localparam int MEM_DEPTH = NUM_LISTS * (1 << $clog2(LIST_DEPTH));

    logic [CFG_W-1:0] active_reg, active_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic              cfg_fire;
    logic              res_free;
    logic              res_valid;
    result_t           res;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ID_W-1:0]   mem_wdata, mem_rdata;

    // Config register
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign active_next = cfg_fire ? cfg_data : active_reg;

    // Output register
    assign res_free       = !out_valid_reg || out_ready;
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);
    assign out_next       = res_valid ? res : out_reg;

    assign out_valid = out_valid_reg;
    assign result_id = out_reg.id;
    assign exhausted = out_reg.exhausted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= ACTIVE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // List contents, one region per list
    sli_ram #(
        .WIDTH (ID_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer
    sli_core #(
        .NUM_LISTS  (NUM_LISTS),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .list_index   (list_index),
        .doc_id       (doc_id),
        .active_lists (active_reg),
        .cfg_restart  (cfg_fire),
        .res_free     (res_free),
        .res_valid    (res_valid),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule

`default_nettype wire

@@ design/sli_checker.sv @@
// ---------------------------------------------------------------------------
// sli_checker
// Port-level checks on the sorted list intersection block, bound to the
// top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_list_intersection_assert.svh"

module sli_checker
    import sli_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            in_valid,
    input wire logic            in_ready,
    input wire logic [1:0]      req_type,
    input wire logic            out_valid,
    input wire logic            out_ready,
    input wire logic [ID_W-1:0] result_id,
    input wire logic            exhausted
);

    logic [1:0] pending_reg, pending_next;
    logic       query_fire, out_fire;

    // Queries taken but not yet answered
    assign query_fire = in_valid && in_ready &&
                        ((req_t'(req_type) == REQ_NEXT) || (req_t'(req_type) == REQ_SKIP));
    assign out_fire   = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (query_fire && !out_fire)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (out_fire && !query_fire)
        begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Stalled result holds
    `SLI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_id) && $stable(exhausted), "result changed while stalled")
    // Exhausted answers carry id zero
    `SLI_ASSERT_IMPLY(a_exh_zero, out_valid && exhausted, result_id == '0, "exhausted result with nonzero id")
    // Every result answers a query
    `SLI_ASSERT_IMPLY(a_no_spurious, out_valid, pending_reg != 2'd0, "result without a pending query")
    // At most one query walking plus one result held
    `SLI_ASSERT_IMPLY(a_one_walk, query_fire, pending_reg == 2'd0 || pending_reg == 2'd1, "query taken while another walks")

endmodule

bind sorted_list_intersection sli_checker u_sli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result_id (result_id),
    .exhausted (exhausted)
);

`default_nettype wire
